>>> rtl/sha1_pkg.sv
`default_nettype none
package sha1_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned NUM_H   = 5;
  localparam int unsigned BLOCK_W = 512;
  localparam int unsigned COUNT_W = 61;
  localparam int unsigned RND_W   = 7;

  // request command codes
  localparam logic CMD_ABSORB = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [BYTE_W-1:0] byte_t;

  localparam word_t H_INIT [NUM_H] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam word_t K_00_19 = 32'h5A827999;
  localparam word_t K_20_39 = 32'h6ED9EBA1;
  localparam word_t K_40_59 = 32'h8F1BBCDC;
  localparam word_t K_60_79 = 32'hCA62C1D6;

  localparam byte_t PAD_BYTE = 8'h80;

  localparam logic [RND_W-1:0] LAST_RND = 7'd79;

endpackage
`default_nettype wire

>>> rtl/sha1_if.sv
`default_nettype none
interface sha1_in_if;
  logic                valid;
  logic                ready;
  logic                cmd;
  sha1_pkg::byte_t     data_byte;

  modport source (output valid, output cmd, output data_byte, input ready);
  modport sink   (input valid, input cmd, input data_byte, output ready);
  modport mon    (input valid, input cmd, input data_byte, input ready);
endinterface

interface sha1_out_if;
  logic                valid;
  logic                ready;
  sha1_pkg::word_t     digest_word0;
  sha1_pkg::word_t     digest_word1;
  sha1_pkg::word_t     digest_word2;
  sha1_pkg::word_t     digest_word3;
  sha1_pkg::word_t     digest_word4;

  modport source (output valid, output digest_word0, output digest_word1,
                  output digest_word2, output digest_word3, output digest_word4,
                  input ready);
  modport sink   (input valid, input digest_word0, input digest_word1,
                  input digest_word2, input digest_word3, input digest_word4,
                  output ready);
  modport mon    (input valid, input digest_word0, input digest_word1,
                  input digest_word2, input digest_word3, input digest_word4,
                  input ready);
endinterface
`default_nettype wire

>>> rtl/sha1_message_digest.sv
// Absorb request: the one that fills a 64-byte block starts 80 rounds and the chaining add.
// Finish request: pads the block out to 64 bytes and compresses it, plus one more padded
//   block when 56 or more bytes are pending, then loads the digest register.
// Throughput is set by the single round unit: one round per cycle, 80 per block.
// Reset (rst_n low, synchronous): chaining words to the SHA-1 IV, counts cleared,
//   output register emptied; the block store itself is not cleared.
`default_nettype none
module sha1_message_digest (
  input  wire logic   clk,
  input  wire logic   rst_n,
  sha1_in_if.sink     in_chan,
  sha1_out_if.source  out_chan
);
  import sha1_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_PAD   = 5'b00010,
    ST_ROUND = 5'b00100,
    ST_FINAL = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_t;

  // control state
  state_t             state_r, state_nxt;
  logic [5:0]         fill_r, fill_nxt;      // bytes in the current block
  logic [COUNT_W-1:0] msg_r, msg_nxt;        // message length in bytes
  logic [RND_W-1:0]   rnd_r, rnd_nxt;        // round counter
  logic               fin_r, fin_nxt;        // finishing a message
  logic               first_r, first_nxt;    // next pad byte is 0x80
  logic               lenok_r, lenok_nxt;    // this pad block carries the length
  logic               out_valid_r, out_valid_nxt;
  word_t              h_r   [NUM_H];
  word_t              h_nxt [NUM_H];

  // payload
  // Block store doubles as the 16-word schedule window: word j sits at
  // blk_r[511-32j -: 32]. Bytes shift in at the bottom; each round shifts
  // out word 0 and appends the next schedule word.
  logic [BLOCK_W-1:0] blk_r, blk_nxt;
  word_t              wv_r   [NUM_H];        // a, b, c, d, e
  word_t              wv_nxt [NUM_H];
  word_t              dig_r  [NUM_H];
  word_t              dig_nxt [NUM_H];

  logic        in_acc;
  logic        load_wv;
  logic [63:0] bit_len;
  byte_t       len_byte;
  byte_t       pad_byte;
  word_t       w0, w2, w8, w13, w_new;
  word_t       f_val, k_val, tmp;

  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_acc        = in_chan.valid && in_chan.ready;

  assign out_chan.valid        = out_valid_r;
  assign out_chan.digest_word0 = dig_r[0];
  assign out_chan.digest_word1 = dig_r[1];
  assign out_chan.digest_word2 = dig_r[2];
  assign out_chan.digest_word3 = dig_r[3];
  assign out_chan.digest_word4 = dig_r[4];

  // length field, big-endian, byte picked by position within bytes 56..63
  assign bit_len  = {msg_r, 3'b000};
  assign len_byte = byte_t'(bit_len >> {~fill_r[2:0], 3'b000});
  assign pad_byte = first_r ? PAD_BYTE :
                    ((lenok_r && (&fill_r[5:3])) ? len_byte : '0);

  // message schedule
  assign w0    = blk_r[511:480];
  assign w2    = blk_r[447:416];
  assign w8    = blk_r[255:224];
  assign w13   = blk_r[95:64];
  assign w_new = {(w13[30:0] ^ w8[30:0] ^ w2[30:0] ^ w0[30:0]),
                  (w13[31] ^ w8[31] ^ w2[31] ^ w0[31])};

  // round function
  always_comb begin
    priority if (rnd_r < 7'd20) begin
      f_val = (wv_r[1] & wv_r[2]) | (~wv_r[1] & wv_r[3]);
      k_val = K_00_19;
    end else if (rnd_r < 7'd40) begin
      f_val = wv_r[1] ^ wv_r[2] ^ wv_r[3];
      k_val = K_20_39;
    end else if (rnd_r < 7'd60) begin
      f_val = (wv_r[1] & wv_r[2]) | (wv_r[1] & wv_r[3]) | (wv_r[2] & wv_r[3]);
      k_val = K_40_59;
    end else begin
      f_val = wv_r[1] ^ wv_r[2] ^ wv_r[3];
      k_val = K_60_79;
    end
  end

  assign tmp = {wv_r[0][26:0], wv_r[0][31:27]} + f_val + wv_r[4] + k_val + w0;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    msg_nxt       = msg_r;
    rnd_nxt       = rnd_r;
    fin_nxt       = fin_r;
    first_nxt     = first_r;
    lenok_nxt     = lenok_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    blk_nxt       = blk_r;
    h_nxt         = h_r;
    wv_nxt        = wv_r;
    dig_nxt       = dig_r;
    load_wv       = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_chan.cmd == CMD_FINISH) begin
            fin_nxt   = 1'b1;
            first_nxt = 1'b1;
            lenok_nxt = !(&fill_r[5:3]);   // tail of 56+ bytes needs an extra block
            state_nxt = ST_PAD;
          end else begin
            blk_nxt  = {blk_r[BLOCK_W-BYTE_W-1:0], in_chan.data_byte};
            fill_nxt = fill_r + 6'd1;
            msg_nxt  = msg_r + COUNT_W'(1);
            if (&fill_r) begin
              load_wv   = 1'b1;
              state_nxt = ST_ROUND;
            end
          end
        end
      end
      ST_PAD: begin
        blk_nxt   = {blk_r[BLOCK_W-BYTE_W-1:0], pad_byte};
        first_nxt = 1'b0;
        fill_nxt  = fill_r + 6'd1;
        if (&fill_r) begin
          load_wv   = 1'b1;
          state_nxt = ST_ROUND;
        end
      end
      ST_ROUND: begin
        wv_nxt[0] = tmp;
        wv_nxt[1] = wv_r[0];
        wv_nxt[2] = {wv_r[1][1:0], wv_r[1][31:2]};
        wv_nxt[3] = wv_r[2];
        wv_nxt[4] = wv_r[3];
        blk_nxt   = {blk_r[BLOCK_W-WORD_W-1:0], w_new};
        if (rnd_r == LAST_RND) begin
          rnd_nxt   = '0;
          state_nxt = ST_FINAL;
        end else begin
          rnd_nxt = rnd_r + 7'd1;
        end
      end
      ST_FINAL: begin
        for (int i = 0; i < NUM_H; i++) begin
          h_nxt[i] = h_r[i] + wv_r[i];
        end
        priority if (!fin_r) begin
          state_nxt = ST_IDLE;
        end else if (lenok_r) begin
          state_nxt = ST_EMIT;
        end else begin
          lenok_nxt = 1'b1;
          state_nxt = ST_PAD;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_chan.ready) begin
          dig_nxt       = h_r;
          out_valid_nxt = 1'b1;
          h_nxt         = H_INIT;
          msg_nxt       = '0;
          fin_nxt       = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (load_wv) begin
      wv_nxt = h_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      msg_r       <= '0;
      rnd_r       <= '0;
      fin_r       <= 1'b0;
      first_r     <= 1'b0;
      lenok_r     <= 1'b0;
      out_valid_r <= 1'b0;
      h_r         <= H_INIT;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      msg_r       <= msg_nxt;
      rnd_r       <= rnd_nxt;
      fin_r       <= fin_nxt;
      first_r     <= first_nxt;
      lenok_r     <= lenok_nxt;
      out_valid_r <= out_valid_nxt;
      h_r         <= h_nxt;
    end
  end

  always_ff @(posedge clk) begin
    blk_r <= blk_nxt;
    wv_r  <= wv_nxt;
    dig_r <= dig_nxt;
  end

endmodule
`default_nettype wire

>>> rtl/sha1_chk.sv
`default_nettype none
module sha1_chk (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire logic             in_ready,
  input  wire logic             in_cmd,
  input  wire logic             out_valid,
  input  wire logic             out_ready,
  input  wire sha1_pkg::word_t  out_word0,
  input  wire sha1_pkg::word_t  out_word4
);
  import sha1_pkg::*;

  logic fin_acc;
  assign fin_acc = in_valid && in_ready && (in_cmd == CMD_FINISH);

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // a finish runs padding and compression before taking more requests
  a_fin_busy: assert property (@(posedge clk) disable iff (!rst_n)
    fin_acc |=> !in_ready)
    else $error("request taken right after finish");

  a_fin_long: assert property (@(posedge clk) disable iff (!rst_n)
    fin_acc |-> ##81 !in_ready)
    else $error("finish completed faster than one compression");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_word0) && $stable(out_word4))
    else $error("result changed while stalled");

endmodule

bind sha1_message_digest sha1_chk u_sha1_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .in_cmd    (in_chan.cmd),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_word0 (out_chan.digest_word0),
  .out_word4 (out_chan.digest_word4)
);
`default_nettype wire
